// File: rtl/ftpp_pkg.sv
// ----------------------------------------------------------------------------
// ftpp_pkg
// Shared types and constants of the file transfer packet parser.
// ----------------------------------------------------------------------------
package ftpp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PosW     = 17;

  localparam logic [CfgIdxW-1:0] CFG_START_CODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_CODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_CODE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_TYPE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NAME_TYPE   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 3'd5;

  localparam logic [PosW-1:0] POS_MAX      = 17'h1FFFF;
  localparam logic [PosW-1:0] DATA_HDR_LEN = 17'd3;
  localparam logic [7:0]      SIZE_REC_LEN = 8'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_DATA  = 2'd1,
    CLS_END   = 2'd2,
    CLS_OTHER = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_OVER     = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  data_code;
    logic [7:0]  end_code;
    logic [7:0]  size_type;
    logic [7:0]  name_type;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    class_e      pclass;
    logic [31:0] file_size;
    logic        size_seen;
    logic [7:0]  name_length;
    logic        name_seen;
    logic [15:0] payload_length;
    status_e     status;
    logic        last;
  } res_t;

endpackage

// File: rtl/ftpp_parse.sv
// ----------------------------------------------------------------------------
// ftpp_parse
// Packet parser state and per-byte update; builds the stream and summary
// items caused by one byte.
// ----------------------------------------------------------------------------
module ftpp_parse import ftpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       strm_vld_o,
  output res_t       strm_o,
  output logic       summ_vld_o,
  output res_t       summ_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  class_e          class_q, class_d;
  logic [15:0]     decl_q, decl_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      rtype_q, rtype_d;
  logic [7:0]      rlen_q, rlen_d;
  logic [7:0]      rrem_q, rrem_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     size_q, size_d;
  logic            size_flag_q, size_flag_d;
  logic [7:0]      nlen_q, nlen_d;
  logic            name_flag_q, name_flag_d;
  logic            is_size, is_name;

  always_comb begin
    pos_d       = pos_q;
    class_d     = class_q;
    decl_d      = decl_q;
    phase_d     = phase_q;
    rtype_d     = rtype_q;
    rlen_d      = rlen_q;
    rrem_d      = rrem_q;
    acc_d       = acc_q;
    size_d      = size_q;
    size_flag_d = size_flag_q;
    nlen_d      = nlen_q;
    name_flag_d = name_flag_q;
    strm_vld_o  = 1'b0;
    strm_o      = '0;
    is_size     = (rtype_q == cfg_i.size_type) && (rlen_q == SIZE_REC_LEN);
    is_name     = !is_size && (rtype_q == cfg_i.name_type);

    if (pos_q == '0) begin
      if (byte_i == cfg_i.start_code) begin
        class_d = CLS_START;
      end else if (byte_i == cfg_i.data_code) begin
        class_d = CLS_DATA;
      end else if (byte_i == cfg_i.end_code) begin
        class_d = CLS_END;
      end else begin
        class_d = CLS_OTHER;
      end
      decl_d      = '0;
      phase_d     = PH_TYPE;
      rtype_d     = '0;
      rlen_d      = '0;
      rrem_d      = '0;
      acc_d       = '0;
      size_d      = '0;
      size_flag_d = 1'b0;
      nlen_d      = '0;
      name_flag_d = 1'b0;
    end else if (class_q == CLS_DATA) begin
      if (pos_q == 17'd1) begin
        decl_d = {byte_i, 8'h00};
      end else if (pos_q == 17'd2) begin
        decl_d = {decl_q[15:8], byte_i};
      end else begin
        strm_vld_o = 1'b1;
        strm_o.kind = KIND_PAYLOAD;
        strm_o.data = byte_i;
      end
    end else if (class_q != CLS_OTHER) begin
      case (phase_q)
        PH_LEN: begin
          rlen_d = byte_i;
          rrem_d = byte_i;
          acc_d  = '0;
          if (byte_i == 8'h00) begin
            // empty record: can only be a name (size needs four bytes)
            phase_d = PH_TYPE;
            if (rtype_q == cfg_i.name_type) begin
              nlen_d      = 8'h00;
              name_flag_d = 1'b1;
            end
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          acc_d  = {acc_q[23:0], byte_i};
          rrem_d = rrem_q - 8'd1;
          if (is_name) begin
            strm_vld_o  = 1'b1;
            strm_o.kind = KIND_NAME;
            strm_o.data = byte_i;
          end
          if (rrem_d == 8'h00) begin
            phase_d = PH_TYPE;
            if (is_size) begin
              size_d      = acc_d;
              size_flag_d = 1'b1;
            end else if (is_name) begin
              nlen_d      = rlen_q;
              name_flag_d = 1'b1;
            end
          end
        end
        default: begin
          rtype_d = byte_i;
          phase_d = PH_LEN;
        end
      endcase
    end

    pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 17'd1;
    pos_d   = last_i ? '0 : pos_inc;

    strm_o.pclass = class_d;
    strm_o.last   = !last_i;

    summ_vld_o      = last_i;
    summ_o          = '0;
    summ_o.kind     = KIND_SUMMARY;
    summ_o.pclass   = class_d;
    summ_o.last     = 1'b1;
    summ_o.status   = ST_OK;
    if (class_d == CLS_DATA) begin
      if (pos_inc < DATA_HDR_LEN) begin
        summ_o.status = ST_SHORT;
      end else begin
        summ_o.payload_length = decl_d;
        if (pos_inc != DATA_HDR_LEN + {1'b0, decl_d}) begin
          summ_o.status = ST_MISMATCH;
        end else if (decl_d > cfg_i.max_payload) begin
          summ_o.status = ST_OVER;
        end
      end
    end else if (class_d != CLS_OTHER) begin
      summ_o.file_size   = size_d;
      summ_o.size_seen   = size_flag_d;
      summ_o.name_length = nlen_d;
      summ_o.name_seen   = name_flag_d;
      if (phase_d == PH_LEN || phase_d == PH_VALUE) begin
        summ_o.status = ST_TRUNC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      class_q     <= CLS_START;
      decl_q      <= '0;
      phase_q     <= PH_TYPE;
      rtype_q     <= '0;
      rlen_q      <= '0;
      rrem_q      <= '0;
      acc_q       <= '0;
      size_q      <= '0;
      size_flag_q <= 1'b0;
      nlen_q      <= '0;
      name_flag_q <= 1'b0;
    end else if (advance_i) begin
      pos_q       <= pos_d;
      class_q     <= class_d;
      decl_q      <= decl_d;
      phase_q     <= phase_d;
      rtype_q     <= rtype_d;
      rlen_q      <= rlen_d;
      rrem_q      <= rrem_d;
      acc_q       <= acc_d;
      size_q      <= size_d;
      size_flag_q <= size_flag_d;
      nlen_q      <= nlen_d;
      name_flag_q <= name_flag_d;
    end
  end

endmodule

// File: rtl/ftpp_outbuf.sv
// ----------------------------------------------------------------------------
// ftpp_outbuf
// Two-slot result register; takes the items of one byte at once and hands
// them out one per handshake.
// ----------------------------------------------------------------------------
module ftpp_outbuf import ftpp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic strm_vld_i,
  input  res_t strm_i,
  input  logic summ_vld_i,
  input  res_t summ_i,
  output logic can_load_o,
  output logic vld_o,
  output res_t res_o,
  input  logic rdy_i
);

  logic v0_q, v0_d, v1_q, v1_d;
  res_t s0_q, s0_d, s1_q, s1_d;
  logic pop;

  assign vld_o = v0_q | v1_q;
  assign res_o = v0_q ? s0_q : s1_q;
  assign pop   = vld_o & rdy_i;
  // room when empty, or when the only item left leaves this cycle
  assign can_load_o = !vld_o || (pop && !(v0_q && v1_q));

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    if (pop) begin
      if (v0_q) begin
        v0_d = 1'b0;
      end else begin
        v1_d = 1'b0;
      end
    end
    if (load_i) begin
      v0_d = strm_vld_i;
      s0_d = strm_i;
      v1_d = summ_vld_i;
      s1_d = summ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

// File: rtl/file_transfer_packet_parser.sv
// ----------------------------------------------------------------------------
// file_transfer_packet_parser
// Each accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle unless the output stalls; a packet's last
// byte yields two items if it is a payload or name byte, and the next byte
// waits for the second. Reset clears parser state and loads register defaults.
// ----------------------------------------------------------------------------
module file_transfer_packet_parser import ftpp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] in_byte
  input  logic                s_axis_tlast_i,  // last_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] out_byte, [9:8] packet_class, [41:10] file_size, [42] size_seen,
  // [50:43] name_length, [51] name_seen, [67:52] payload_length,
  // [70:68] status, [71] zero
  output logic [71:0]         m_axis_tdata_o,
  output logic [1:0]          m_axis_tuser_o,  // [1:0] result_kind
  output logic                m_axis_tlast_o   // last_of_run
);

  cfg_t       cfg_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance, can_load;
  logic       strm_vld, summ_vld;
  res_t       strm, summ, res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code  <= 8'd1;
      cfg_q.data_code   <= 8'd2;
      cfg_q.end_code    <= 8'd3;
      cfg_q.size_type   <= 8'd0;
      cfg_q.name_type   <= 8'd1;
      cfg_q.max_payload <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_CODE:  cfg_q.start_code  <= cfg_data_i[7:0];
        CFG_DATA_CODE:   cfg_q.data_code   <= cfg_data_i[7:0];
        CFG_END_CODE:    cfg_q.end_code    <= cfg_data_i[7:0];
        CFG_SIZE_TYPE:   cfg_q.size_type   <= cfg_data_i[7:0];
        CFG_NAME_TYPE:   cfg_q.name_type   <= cfg_data_i[7:0];
        CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance         = in_vld_q & can_load;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  ftpp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .advance_i  (advance),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .strm_vld_o (strm_vld),
    .strm_o     (strm),
    .summ_vld_o (summ_vld),
    .summ_o     (summ)
  );

  ftpp_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .strm_vld_i (strm_vld),
    .strm_i     (strm),
    .summ_vld_i (summ_vld),
    .summ_i     (summ),
    .can_load_o (can_load),
    .vld_o      (m_axis_tvalid_o),
    .res_o      (res),
    .rdy_i      (m_axis_tready_i)
  );

  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;
  assign m_axis_tdata_o = {1'b0, res.status, res.payload_length, res.name_seen,
                           res.name_length, res.size_seen, res.file_size,
                           res.pclass, res.data};

endmodule

// File: verif/file_transfer_packet_parser_tb.sv
// ----------------------------------------------------------------------------
// file_transfer_packet_parser_tb
// Self-checking bench for the packet parser. A short table of hand-built
// packets comes first, then random well-formed and broken packets under
// several register settings and flow-control patterns. A behavioral parser
// predicts every output item and each one is compared field by field as it
// leaves the block.
// ----------------------------------------------------------------------------
module file_transfer_packet_parser_tb import ftpp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 120;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    logic [7:0]          b;
    logic                l;
    logic                typed;
    class_e              cls;
    status_e             st;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_valid;
  logic                s_ready;
  logic [7:0]          s_data;
  logic                s_last;
  logic                m_valid;
  logic                m_ready;
  logic [71:0]         m_data;
  logic [1:0]          m_user;
  logic                m_last;

  file_transfer_packet_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // parser model state, mirrors the block's registers
  cfg_t        cfg;
  logic [16:0] p_pos      = '0;
  class_e      p_cls      = CLS_START;
  logic [15:0] p_decl     = '0;
  phase_e      p_phase    = PH_TYPE;
  logic [7:0]  p_rec_type = '0;
  logic [7:0]  p_rec_len  = '0;
  logic [7:0]  p_rec_rem  = '0;
  logic [31:0] p_size_acc = '0;
  logic [31:0] p_size_val = '0;
  logic        p_size_ok  = 1'b0;
  logic [7:0]  p_name_len = '0;
  logic        p_name_ok  = 1'b0;

  res_t        exp_items[$];
  logic [7:0]  pkt_q[$];
  stim_row_t   dir_tbl[$];
  int unsigned err_cnt = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        long_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_err(input string what, input logic [31:0] want_v,
                            input logic [31:0] got_v);
    if (err_cnt < 200) begin
      $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      report_err(what, want_v, got_v);
    end
  endtask

  function automatic res_t mk_res(kind_e k, logic [7:0] b);
    res_t r;
    r = '0;
    r.kind = k;
    r.data = b;
    r.pclass = p_cls;
    return r;
  endfunction

  function automatic logic is_size_rec();
    return (p_rec_type == cfg.size_type) && (p_rec_len == SIZE_REC_LEN);
  endfunction

  function automatic logic is_name_rec();
    return !is_size_rec() && (p_rec_type == cfg.name_type);
  endfunction

  function automatic void close_record();
    if (is_size_rec()) begin
      p_size_val = p_size_acc;
      p_size_ok = 1'b1;
    end else if (is_name_rec()) begin
      p_name_len = p_rec_len;
      p_name_ok = 1'b1;
    end
    p_phase = PH_TYPE;
  endfunction

  // Advance the model by one accepted byte and queue the items it causes.
  task automatic predict_byte(input logic [7:0] b, input logic l);
    res_t step_q[$];
    res_t r;
    if (p_pos == '0) begin
      if (b == cfg.start_code) begin
        p_cls = CLS_START;
      end else if (b == cfg.data_code) begin
        p_cls = CLS_DATA;
      end else if (b == cfg.end_code) begin
        p_cls = CLS_END;
      end else begin
        p_cls = CLS_OTHER;
      end
      p_decl = '0;
      p_phase = PH_TYPE;
      p_rec_type = '0;
      p_rec_len = '0;
      p_rec_rem = '0;
      p_size_acc = '0;
      p_size_val = '0;
      p_size_ok = 1'b0;
      p_name_len = '0;
      p_name_ok = 1'b0;
    end else if (p_cls == CLS_DATA) begin
      if (p_pos == 17'd1) begin
        p_decl = {b, 8'h00};
      end else if (p_pos == 17'd2) begin
        p_decl[7:0] = b;
      end else begin
        step_q.push_back(mk_res(KIND_PAYLOAD, b));
      end
    end else if (p_cls != CLS_OTHER) begin
      case (p_phase)
        PH_LEN: begin
          p_rec_len = b;
          p_rec_rem = b;
          p_size_acc = '0;
          if (b == 8'h00) begin
            close_record();
          end else begin
            p_phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          p_size_acc = {p_size_acc[23:0], b};
          if (is_name_rec()) begin
            step_q.push_back(mk_res(KIND_NAME, b));
          end
          p_rec_rem = p_rec_rem - 8'd1;
          if (p_rec_rem == 8'h00) begin
            close_record();
          end
        end
        default: begin
          p_rec_type = b;
          p_phase = PH_LEN;
        end
      endcase
    end

    if (p_pos != POS_MAX) begin
      p_pos = p_pos + 17'd1;
    end

    if (l) begin
      r = mk_res(KIND_SUMMARY, 8'h00);
      if (p_cls == CLS_DATA) begin
        if (p_pos < DATA_HDR_LEN) begin
          r.status = ST_SHORT;
        end else begin
          r.payload_length = p_decl;
          if (p_pos != DATA_HDR_LEN + p_decl) begin
            r.status = ST_MISMATCH;
          end else if (p_decl > cfg.max_payload) begin
            r.status = ST_OVER;
          end
        end
      end else if (p_cls != CLS_OTHER) begin
        r.file_size = p_size_val;
        r.size_seen = p_size_ok;
        r.name_length = p_name_len;
        r.name_seen = p_name_ok;
        if (p_phase == PH_LEN || p_phase == PH_VALUE) begin
          r.status = ST_TRUNC;
        end
      end
      step_q.push_back(r);
      p_pos = '0;
    end

    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].last = 1'b1;
    end
    foreach (step_q[i]) begin
      exp_items.push_back(step_q[i]);
    end
  endtask

  // Output side: accepted items against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_valid && m_ready) begin
      got.kind           = kind_e'(m_user);
      got.data           = m_data[7:0];
      got.pclass         = class_e'(m_data[9:8]);
      got.file_size      = m_data[41:10];
      got.size_seen      = m_data[42];
      got.name_length    = m_data[50:43];
      got.name_seen      = m_data[51];
      got.payload_length = m_data[67:52];
      got.status         = status_e'(m_data[70:68]);
      got.last           = m_last;
      if (exp_items.size() == 0) begin
        report_err("item with nothing expected, byte", 32'h0, {24'h0, got.data});
      end else begin
        want = exp_items.pop_front();
        check_field("result_kind", want.kind, got.kind);
        check_field("out_byte", want.data, got.data);
        check_field("packet_class", want.pclass, got.pclass);
        check_field("file_size", want.file_size, got.file_size);
        check_field("size_seen", want.size_seen, got.size_seen);
        check_field("name_length", want.name_length, got.name_length);
        check_field("name_seen", want.name_seen, got.name_seen);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("status", want.status, got.status);
        check_field("last_of_run", want.last, got.last);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin : receiver
    int unsigned hold_cnt;
    hold_cnt = 0;
    m_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold && hold_cnt < HoldCycles) begin
        m_ready <= 1'b0;
        hold_cnt++;
      end else begin
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= l;
    do @(posedge clk_i); while (!s_ready);
    predict_byte(b, l);
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) begin
      send_byte(pkt_q[i], i == pkt_q.size() - 1);
    end
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (exp_items.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_START_CODE:  cfg.start_code = val[7:0];
      CFG_DATA_CODE:   cfg.data_code = val[7:0];
      CFG_END_CODE:    cfg.end_code = val[7:0];
      CFG_SIZE_TYPE:   cfg.size_type = val[7:0];
      CFG_NAME_TYPE:   cfg.name_type = val[7:0];
      CFG_MAX_PAYLOAD: cfg.max_payload = val;
      default: ;
    endcase
  endtask

  // Caller lowers the write enable after the last write.
  task automatic apply_cfg(input cfg_t c);
    write_reg(CFG_START_CODE, {8'h00, c.start_code});
    write_reg(CFG_DATA_CODE, {8'h00, c.data_code});
    write_reg(CFG_END_CODE, {8'h00, c.end_code});
    write_reg(CFG_SIZE_TYPE, {8'h00, c.size_type});
    write_reg(CFG_NAME_TYPE, {8'h00, c.name_type});
    write_reg(CFG_MAX_PAYLOAD, c.max_payload);
  endtask

  // Fills pkt_q; parsed is low for noise packets, whose first byte may still match a code.
  task automatic build_packet(output bit parsed);
    int unsigned sel, len, n, recs, t, k;
    logic [7:0]  rtype;
    pkt_q.delete();
    parsed = 1'b1;
    sel = $urandom_range(99);
    if (sel < 35) begin
      if ($urandom_range(19) == 0 && cfg.max_payload < 300) begin
        len = cfg.max_payload + $urandom_range(1);
      end else begin
        len = $urandom_range(12);
      end
      pkt_q.push_back(cfg.data_code);
      pkt_q.push_back(len[15:8]);
      pkt_q.push_back(len[7:0]);
      n = len;
      t = $urandom_range(15);
      if (t < 2) begin
        n = len + 1 + $urandom_range(1);
      end else if (t < 4 && len > 0) begin
        n = len - 1;
      end
      for (k = 0; k < n; k++) pkt_q.push_back($urandom_range(255));
      if (t == 15) begin
        k = $urandom_range(1) + 1;
        while (pkt_q.size() > k) pkt_q.delete(pkt_q.size() - 1);
      end
    end else if (sel < 75) begin
      pkt_q.push_back($urandom_range(1) ? cfg.start_code : cfg.end_code);
      recs = $urandom_range(4);
      repeat (recs) begin
        case ($urandom_range(3))
          0: begin
            rtype = cfg.size_type;
            len = SIZE_REC_LEN;
          end
          1: begin
            rtype = cfg.name_type;
            len = $urandom_range(6);
          end
          2: begin
            // size type with a length other than four
            rtype = cfg.size_type;
            len = $urandom_range(5);
            if (len >= SIZE_REC_LEN) len++;
          end
          default: begin
            rtype = $urandom_range(255);
            len = $urandom_range(5);
          end
        endcase
        pkt_q.push_back(rtype);
        pkt_q.push_back(len[7:0]);
        repeat (len) pkt_q.push_back($urandom_range(255));
      end
      if ($urandom_range(5) == 0 && pkt_q.size() > 1) begin
        k = $urandom_range(pkt_q.size() - 2) + 1;
        while (pkt_q.size() > k) pkt_q.delete(pkt_q.size() - 1);
      end
    end else begin
      // unknown code or plain noise
      parsed = 1'b0;
      n = 1 + $urandom_range(5);
      repeat (n) pkt_q.push_back($urandom_range(255));
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned cnt;
    bit          parsed;
    cnt = 0;
    while (cnt < n_items) begin
      build_packet(parsed);
      send_packet();
      if (parsed) cnt += pkt_q.size();
    end
    drain_results();
  endtask

  function automatic stim_row_t pkt_byte(logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.b = b;
    return r;
  endfunction

  function automatic stim_row_t pkt_end(logic [7:0] b, class_e c, status_e s);
    stim_row_t r;
    r = '0;
    r.b = b;
    r.l = 1'b1;
    r.typed = 1'b1;
    r.cls = c;
    r.st = s;
    return r;
  endfunction

  function automatic stim_row_t reg_wr(logic [CfgIdxW-1:0] i, logic [CfgDataW-1:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = i;
    r.val = v;
    return r;
  endfunction

  initial begin : stimulus
    int unsigned ph;
    cfg_t        next_cfg;

    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    s_valid  = 1'b0;
    s_data   = '0;
    s_last   = 1'b0;
    cfg.start_code  = 8'd1;
    cfg.data_code   = 8'd2;
    cfg.end_code    = 8'd3;
    cfg.size_type   = 8'd0;
    cfg.name_type   = 8'd1;
    cfg.max_payload = 16'd256;

    // start packet without records; data packet that is only its code
    dir_tbl.push_back(pkt_end(8'h01, CLS_START, ST_OK));
    dir_tbl.push_back(pkt_end(8'h02, CLS_DATA, ST_SHORT));
    // one payload byte at its top value
    dir_tbl.push_back(pkt_byte(8'h02)); dir_tbl.push_back(pkt_byte(8'h00));
    dir_tbl.push_back(pkt_byte(8'h01)); dir_tbl.push_back(pkt_end(8'hFF, CLS_DATA, ST_OK));
    // largest declared length with nothing behind it
    dir_tbl.push_back(pkt_byte(8'h02)); dir_tbl.push_back(pkt_byte(8'hFF));
    dir_tbl.push_back(pkt_end(8'hFF, CLS_DATA, ST_MISMATCH));
    dir_tbl.push_back(reg_wr(CFG_MAX_PAYLOAD, 16'h0000));
    dir_tbl.push_back(pkt_byte(8'h02)); dir_tbl.push_back(pkt_byte(8'h00));
    dir_tbl.push_back(pkt_byte(8'h01)); dir_tbl.push_back(pkt_end(8'h00, CLS_DATA, ST_OVER));
    dir_tbl.push_back(reg_wr(CFG_MAX_PAYLOAD, 16'hFFFF));
    // all-ones size record, then an empty name
    dir_tbl.push_back(pkt_byte(8'h01)); dir_tbl.push_back(pkt_byte(8'h00));
    dir_tbl.push_back(pkt_byte(8'h04)); dir_tbl.push_back(pkt_byte(8'hFF));
    dir_tbl.push_back(pkt_byte(8'hFF)); dir_tbl.push_back(pkt_byte(8'hFF));
    dir_tbl.push_back(pkt_byte(8'hFF)); dir_tbl.push_back(pkt_byte(8'h01));
    dir_tbl.push_back(pkt_end(8'h00, CLS_START, ST_OK));
    // name record cut inside its value
    dir_tbl.push_back(pkt_byte(8'h03)); dir_tbl.push_back(pkt_byte(8'h01));
    dir_tbl.push_back(pkt_byte(8'h02)); dir_tbl.push_back(pkt_end(8'h41, CLS_END, ST_TRUNC));
    dir_tbl.push_back(pkt_end(8'hFF, CLS_OTHER, ST_OK));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        drain_results();
        write_reg(dir_tbl[i].idx, dir_tbl[i].val);
        cfg_we <= 1'b0;
      end else begin
        send_byte(dir_tbl[i].b, dir_tbl[i].l);
        if (dir_tbl[i].typed) begin
          exp_items[exp_items.size()-1].pclass = dir_tbl[i].cls;
          exp_items[exp_items.size()-1].status = dir_tbl[i].st;
        end
      end
    end
    drain_results();

    for (ph = 0; ph < 8; ph++) begin
      case ((ph + ph / 4) % 4)
        0: begin
          next_cfg.start_code  = $urandom_range(255);
          next_cfg.data_code   = $urandom_range(255);
          next_cfg.end_code    = $urandom_range(255);
          next_cfg.size_type   = $urandom_range(255);
          next_cfg.name_type   = $urandom_range(255);
          next_cfg.max_payload = $urandom_range(40);
        end
        1: begin
          // data and end share a code; size and name share a type
          next_cfg.start_code  = 8'hFF;
          next_cfg.data_code   = 8'h00;
          next_cfg.end_code    = 8'h00;
          next_cfg.size_type   = 8'hFF;
          next_cfg.name_type   = 8'hFF;
          next_cfg.max_payload = 16'h0000;
        end
        2: begin
          next_cfg.start_code  = 8'h00;
          next_cfg.data_code   = 8'h00;
          next_cfg.end_code    = 8'hFF;
          next_cfg.size_type   = 8'h00;
          next_cfg.name_type   = 8'h00;
          next_cfg.max_payload = 16'hFFFF;
        end
        default: begin
          next_cfg.start_code  = 8'd1;
          next_cfg.data_code   = 8'd2;
          next_cfg.end_code    = 8'd3;
          next_cfg.size_type   = 8'd0;
          next_cfg.name_type   = 8'd1;
          next_cfg.max_payload = 16'd256;
        end
      endcase
      apply_cfg(next_cfg);
      cfg_we <= 1'b0;
      case (ph % 4)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct <= 0;
        end
        1: begin
          snd_idle_pct = 75;
          rcv_stall_pct <= 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct <= 75;
        end
        default: begin
          snd_idle_pct = 37;
          rcv_stall_pct <= 37;
        end
      endcase
      // output held off while the sender keeps pushing
      if (ph == 4) long_hold <= 1'b1;
      run_random(PhaseItems);
    end

    // back to the reset settings for a few more packets
    next_cfg.start_code  = 8'd1;
    next_cfg.data_code   = 8'd2;
    next_cfg.end_code    = 8'd3;
    next_cfg.size_type   = 8'd0;
    next_cfg.name_type   = 8'd1;
    next_cfg.max_payload = 16'd256;
    apply_cfg(next_cfg);
    cfg_we <= 1'b0;
    snd_idle_pct = 0;
    rcv_stall_pct <= 0;
    run_random(20);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
